### sv/pending_reply_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// Pending reply tracker assertion macros
// Shared concurrent assertion forms for the tracker checker.
// ----------------------------------------------------------------------------
`ifndef PENDING_REPLY_TRACKER_CORE_ASSERT_SVH
`define PENDING_REPLY_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PRT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define PRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Types, codes and opcode tables of the pending reply tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prt_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// item kinds
	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_REPLY   = 2'd1;
	localparam logic [1:0] OP_ERROR   = 2'd2;
	localparam logic [1:0] OP_EVENT   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_NO_REPLY  = 3'd0;
	localparam logic [2:0] ST_QUEUED    = 3'd1;
	localparam logic [2:0] ST_MATCHED   = 3'd2;
	localparam logic [2:0] ST_UNMATCHED = 3'd3;
	localparam logic [2:0] ST_IGNORED   = 3'd4;
	localparam logic [2:0] ST_EVENT     = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;

	// code classes
	localparam logic [1:0] CLS_CORE     = 2'd0;
	localparam logic [1:0] CLS_EXTENDED = 2'd1;
	localparam logic [1:0] CLS_ILLEGAL  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_MOVE_CUTOFF = 2'd0;
	localparam logic [1:0] CFG_SEQ_OFFSET  = 2'd1;

	localparam logic [16:0] MOVE_CUTOFF_RST = 17'h1FFFF;
	localparam logic [7:0]  ERR_CORE_LAST   = 8'd17;
	localparam logic [6:0]  EVT_CORE_FIRST  = 7'd2;
	localparam logic [6:0]  EVT_CORE_END    = 7'd35;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_SHIFT
	} prt_state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  code;
		logic [15:0] seq;
	} prt_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  request_type;
		logic [15:0] out_seq;
		logic [1:0]  code_class;
	} prt_out_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [6:0]  rtype;
	} prt_entry_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		prt_entry_t         wdata;
		logic [IDX_W-1:0]   raddr;
	} prt_ram_req_t;

	typedef struct packed {
		logic signed [16:0] move_cutoff;
		logic [15:0]        seq_offset;
		logic               cutoff_disabled;
	} prt_cfg_t;

	function automatic logic expects_reply(input logic [7:0] c);
		return c inside {8'd3, 8'd14, 8'd15, 8'd16, 8'd17, 8'd20, 8'd21, 8'd23, 8'd26,
			8'd31, 8'd38, 8'd39, 8'd40, 8'd43, 8'd44, 8'd47, 8'd48, 8'd49, 8'd50,
			8'd52, 8'd73, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd91, 8'd92, 8'd97,
			8'd98, 8'd99, 8'd101, 8'd103, 8'd106, 8'd108, 8'd110, 8'd116, 8'd117,
			8'd118, 8'd119};
	endfunction

	function automatic logic [1:0] request_class(input logic [7:0] c);
		logic [1:0] r;
		if (c == 8'd0 || c[7])
			r = CLS_EXTENDED;
		else if (c inside {[8'd120:8'd126]})
			r = CLS_ILLEGAL;
		else
			r = CLS_CORE;
		return r;
	endfunction

	function automatic logic [1:0] error_class(input logic [7:0] c);
		return (c != 8'd0 && c <= ERR_CORE_LAST) ? CLS_CORE : CLS_EXTENDED;
	endfunction

	function automatic logic [1:0] event_class(input logic [7:0] c);
		return (c[6:0] >= EVT_CORE_FIRST && c[6:0] < EVT_CORE_END) ? CLS_CORE : CLS_EXTENDED;
	endfunction

endpackage

`default_nettype wire

### sv/prt_pend_ram.sv
// ----------------------------------------------------------------------------
// prt_pend_ram
// Pending request store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prt_pend_ram (
	input  wire logic                 clk,
	input  wire prt_pkg::prt_ram_req_t req,
	output prt_pkg::prt_entry_t       rdata
);

	prt_pkg::prt_entry_t mem [prt_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

### sv/prt_ctrl.sv
// ----------------------------------------------------------------------------
// prt_ctrl
// Sequencer: request queuing, oldest-first search and shift-down removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prt_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire prt_pkg::prt_in_t     item,
	input  wire prt_pkg::prt_cfg_t    cfg,
	output logic                      busy,
	output logic                      done,
	output prt_pkg::prt_out_t         result,
	output logic                      wrap,
	output prt_pkg::prt_ram_req_t     ram_req,
	input  wire prt_pkg::prt_entry_t  ram_rdata
);

	localparam int IDX_W = prt_pkg::IDX_W;
	localparam int CNT_W = prt_pkg::CNT_W;

	prt_pkg::prt_state_t state_q, state_d;
	logic [15:0]      seq_cnt_q, seq_cnt_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             done_q, done_d;
	prt_pkg::prt_in_t  item_q, item_d;
	logic [6:0]       hit_type_q, hit_type_d;
	prt_pkg::prt_out_t result_q, result_d;

	logic [CNT_W-1:0]   idx_p1, idx_p2;
	logic signed [16:0] cut, seq_s;

	// result of a kept reply or error
	function automatic prt_pkg::prt_out_t close_res(input prt_pkg::prt_in_t it,
			input logic [15:0] offset, input logic hit, input logic [6:0] rtype);
		prt_pkg::prt_out_t r;
		r.status       = hit ? prt_pkg::ST_MATCHED : prt_pkg::ST_UNMATCHED;
		r.request_type = hit ? rtype : 7'd0;
		r.out_seq      = it.seq + offset;
		if (it.op == prt_pkg::OP_REPLY)
			r.code_class = (hit && prt_pkg::expects_reply({1'b0, rtype})) ?
				prt_pkg::CLS_CORE : prt_pkg::CLS_EXTENDED;
		else
			r.code_class = prt_pkg::error_class(it.code);
		return r;
	endfunction

	assign idx_p1 = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_p2 = CNT_W'(idx_q) + CNT_W'(2);
	assign cut    = cfg.cutoff_disabled ? -17'sd1 : cfg.move_cutoff;
	assign seq_s  = signed'({1'b0, item.seq});

	always_comb begin
		state_d       = state_q;
		seq_cnt_d     = seq_cnt_q;
		count_d       = count_q;
		idx_d         = idx_q;
		item_d        = item_q;
		hit_type_d    = hit_type_q;
		result_d      = result_q;
		done_d        = 1'b0;
		wrap          = 1'b0;
		ram_req       = '0;
		ram_req.raddr = idx_p1[IDX_W-1:0];

		case (state_q)
			prt_pkg::FSM_IDLE: begin
				if (start) begin
					item_d   = item;
					result_d = '0;
					case (item.op)
						prt_pkg::OP_REQUEST: begin
							seq_cnt_d           = seq_cnt_q + 16'd1;
							wrap                = (seq_cnt_d == 16'd0);
							done_d              = 1'b1;
							result_d.out_seq    = seq_cnt_d;
							result_d.code_class = prt_pkg::request_class(item.code);
							result_d.status     = prt_pkg::ST_NO_REPLY;
							if (prt_pkg::expects_reply(item.code)) begin
								if (count_q != CNT_W'(prt_pkg::DEPTH)) begin
									ram_req.we          = 1'b1;
									ram_req.waddr       = count_q[IDX_W-1:0];
									ram_req.wdata.seq   = seq_cnt_d;
									ram_req.wdata.rtype = item.code[6:0];
									count_d             = count_q + CNT_W'(1);
									result_d.status     = prt_pkg::ST_QUEUED;
								end else begin
									result_d.status = prt_pkg::ST_FULL;
								end
							end
						end
						prt_pkg::OP_REPLY, prt_pkg::OP_ERROR: begin
							if (seq_s <= cut) begin
								done_d          = 1'b1;
								result_d.status = prt_pkg::ST_IGNORED;
							end else if (count_q == '0) begin
								done_d   = 1'b1;
								result_d = close_res(item, cfg.seq_offset, 1'b0, 7'd0);
							end else begin
								state_d       = prt_pkg::FSM_SEARCH;
								idx_d         = '0;
								ram_req.raddr = '0;
							end
						end
						default: begin
							done_d = 1'b1;
							if (seq_s < cut) begin
								result_d.status = prt_pkg::ST_IGNORED;
							end else begin
								result_d.status     = prt_pkg::ST_EVENT;
								result_d.out_seq    = item.seq + cfg.seq_offset;
								result_d.code_class = prt_pkg::event_class(item.code);
							end
						end
					endcase
				end
			end
			prt_pkg::FSM_SEARCH: begin
				// ram_rdata holds entry idx_q; entry idx_q+1 is being read
				if (ram_rdata.seq == item_q.seq) begin
					hit_type_d = ram_rdata.rtype;
					if (idx_p1 == count_q) begin
						done_d   = 1'b1;
						result_d = close_res(item_q, cfg.seq_offset, 1'b1, ram_rdata.rtype);
						count_d  = count_q - CNT_W'(1);
						state_d  = prt_pkg::FSM_IDLE;
					end else begin
						state_d = prt_pkg::FSM_SHIFT;
					end
				end else if (idx_p1 == count_q) begin
					done_d   = 1'b1;
					result_d = close_res(item_q, cfg.seq_offset, 1'b0, 7'd0);
					state_d  = prt_pkg::FSM_IDLE;
				end else begin
					idx_d = idx_p1[IDX_W-1:0];
				end
			end
			prt_pkg::FSM_SHIFT: begin
				// ram_rdata holds entry idx_q+1, moved down to idx_q
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q;
				ram_req.wdata = ram_rdata;
				if (idx_p2 == count_q) begin
					done_d   = 1'b1;
					result_d = close_res(item_q, cfg.seq_offset, 1'b1, hit_type_q);
					count_d  = count_q - CNT_W'(1);
					state_d  = prt_pkg::FSM_IDLE;
				end else begin
					ram_req.raddr = idx_p2[IDX_W-1:0];
					idx_d         = idx_p1[IDX_W-1:0];
				end
			end
			default: begin
				state_d = prt_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= prt_pkg::FSM_IDLE;
			seq_cnt_q <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			seq_cnt_q <= seq_cnt_d;
			count_q   <= count_d;
			idx_q     <= idx_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q     <= item_d;
		hit_type_q <= hit_type_d;
		result_q   <= result_d;
	end

	assign busy   = (state_q != prt_pkg::FSM_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

### sv/pending_reply_tracker_core.sv
// ----------------------------------------------------------------------------
// pending_reply_tracker_core
// Tracks outstanding requests that expect replies and matches replies.
// ----------------------------------------------------------------------------
// Usage:
//  - Items enter on item when start is high and busy is low. Each item
//    produces exactly one result on result, marked by a one-cycle done
//    strobe; the receiver always takes it, there is no back-pressure.
//  - Requests, events and ignored replies/errors: busy stays low, the
//    result shows in the cycle after the transfer, and a new item may
//    follow immediately.
//  - Kept replies/errors walk the pending store one entry per cycle
//    (oldest first) and then shift later entries down one per cycle on a
//    hit. busy stays high meanwhile; the result comes as busy falls, and
//    the next item can transfer once busy is low. With an empty store the
//    result comes the next cycle.
//  - The store's single read and write ports set this pace.
//  - Configuration: cfg_valid/cfg_ready transfer, cfg_index 0 is
//    move_cutoff (also re-arms the cutoff), 1 is seq_offset, others are
//    dropped. cfg_ready is always high; write only while idle.
//  - Reset clears counter, fill count and cutoff state; store contents
//    stay undefined and are never used past the fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pending_reply_tracker_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire prt_pkg::prt_in_t  item,
	output logic                   done,
	output prt_pkg::prt_out_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [16:0]       cfg_data
);

	logic [16:0] move_cutoff_q;
	logic [15:0] seq_offset_q;
	logic        cutoff_dis_q;
	logic        wrap;
	logic        cfg_wr;

	prt_pkg::prt_cfg_t     cfg;
	prt_pkg::prt_ram_req_t ram_req;
	prt_pkg::prt_entry_t   ram_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// register file; a counter wrap disables the cutoff until it is rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_cutoff_q <= prt_pkg::MOVE_CUTOFF_RST;
			seq_offset_q  <= '0;
			cutoff_dis_q  <= 1'b0;
		end else begin
			if (wrap)
				cutoff_dis_q <= 1'b1;
			if (cfg_wr) begin
				case (cfg_index)
					prt_pkg::CFG_MOVE_CUTOFF: begin
						move_cutoff_q <= cfg_data;
						cutoff_dis_q  <= 1'b0;
					end
					prt_pkg::CFG_SEQ_OFFSET: begin
						seq_offset_q <= cfg_data[15:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg.move_cutoff     = signed'(move_cutoff_q);
	assign cfg.seq_offset      = seq_offset_q;
	assign cfg.cutoff_disabled = cutoff_dis_q;

	prt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg       (cfg),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.wrap      (wrap),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	prt_pend_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

### sv/prt_checker.sv
// ----------------------------------------------------------------------------
// prt_checker
// Port-level temporal checks of the pending reply tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pending_reply_tracker_core_assert.svh"

module prt_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire prt_pkg::prt_in_t  item,
	input wire logic              done,
	input wire prt_pkg::prt_out_t result
);

	`PRT_ASSERT_NEXT(a_req_result_next, clk, arst_n, start && !busy && item.op == prt_pkg::OP_REQUEST, done && !busy && (result.status == prt_pkg::ST_NO_REPLY || result.status == prt_pkg::ST_QUEUED || result.status == prt_pkg::ST_FULL), "request result not in the next cycle")
	`PRT_ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, busy || done, "accepted item neither busy nor done")
	`PRT_ASSERT_SAME(a_fall_done, clk, arst_n, $fell(busy), done, "search ended without a result")
	`PRT_ASSERT_SAME(a_type_only_match, clk, arst_n, done && result.status != prt_pkg::ST_MATCHED, result.request_type == 7'd0 && (result.status != prt_pkg::ST_IGNORED || (result.out_seq == 16'd0 && result.code_class == prt_pkg::CLS_CORE)), "stray fields in result")

endmodule

bind pending_reply_tracker_core prt_checker u_prt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

`default_nettype wire
